[hw/rtl/rsn_pkg.sv]
// Shared types and constants for the RootSIFT row normalizer.
`default_nettype none
package rsn_pkg;

   localparam int ELEM_W     = 16;               // element and result width
   localparam int FRAC_SHIFT = 32;               // element * 2^32 before the divide
   localparam int QUOT_W     = FRAC_SHIFT + 1;   // quotient can reach exactly 2^32
   localparam int ROOT_W     = FRAC_SHIFT / 2;   // integer square root of a 32-bit value
   localparam int ROW_LEN_DEFAULT = 64;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_START,
      ST_DIV,
      ST_SQRT,
      ST_PUT
   } state_type;

   typedef struct packed {
      logic              done;
      logic [QUOT_W-1:0] quotient;
   } div_status_type;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_status_type;

endpackage
`default_nettype wire

[hw/rtl/rsn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rsn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

[hw/rtl/rsn_divider.sv]
// Bit-serial restoring divider: floor(element * 2^32 / sum), one quotient bit per cycle.
`default_nettype none
module rsn_divider #(
   parameter int SUM_W = 22
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [rsn_pkg::ELEM_W-1:0] dividend,
   input  wire logic [SUM_W-1:0]           divisor,   // held stable while busy
   output rsn_pkg::div_status_type         status
);

   localparam int CNT_W = $clog2(rsn_pkg::FRAC_SHIFT + 1);

   logic [SUM_W-1:0]           rem_ff, rem_in;
   logic [rsn_pkg::QUOT_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;

   logic [SUM_W-1:0] dividend_ext;
   logic             top_bit;
   logic [SUM_W:0]   rem_dbl;
   logic             ge;

   always_comb begin
      dividend_ext = SUM_W'(dividend);
      top_bit      = (dividend_ext >= divisor);
      rem_dbl      = {rem_ff, 1'b0};
      ge           = (rem_dbl >= {1'b0, divisor});

      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         // element never exceeds the sum, so the integer part is one bit
         rem_in  = top_bit ? (dividend_ext - divisor) : dividend_ext;
         quot_in = rsn_pkg::QUOT_W'(top_bit);
         cnt_in  = CNT_W'(rsn_pkg::FRAC_SHIFT);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? SUM_W'(rem_dbl - {1'b0, divisor}) : SUM_W'(rem_dbl);
         quot_in = {quot_ff[rsn_pkg::QUOT_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign status.done     = done_ff;
   assign status.quotient = quot_ff;

endmodule
`default_nettype wire

[hw/rtl/rsn_sqrt.sv]
// Digit-serial integer square root of a 32-bit value, one root bit per cycle.
`default_nettype none
module rsn_sqrt (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [rsn_pkg::FRAC_SHIFT-1:0] radicand,
   output rsn_pkg::sqrt_status_type            status
);

   localparam int ROOT_W = rsn_pkg::ROOT_W;
   localparam int REM_W  = ROOT_W + 1;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [rsn_pkg::FRAC_SHIFT-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]               rem_ff, rem_in;
   logic [ROOT_W-1:0]              root_ff, root_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [REM_W+1:0] rem_sh;
   logic [REM_W+1:0] trial;
   logic             ge;

   always_comb begin
      rem_sh = {rem_ff, rad_ff[rsn_pkg::FRAC_SHIFT-1 -: 2]};
      trial  = (REM_W + 2)'({root_ff, 2'b01});
      ge     = (rem_sh >= trial);

      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // bring down two radicand bits, try appending a one to the root
         rad_in  = {rad_ff[rsn_pkg::FRAC_SHIFT-3:0], 2'b00};
         rem_in  = ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign status.done = done_ff;
   assign status.root = root_ff;

endmodule
`default_nettype wire

[hw/rtl/rootsift_row_normalizer.sv]
// Top level of the RootSIFT row normalizer: row store, L1 sum and result sequencing.
// Loading accepts one word per cycle; a row closes on tlast or after ROW_LEN words.
// Each result then runs through a RAM read, a bit-serial divide, a bit-serial
// square root and an output load in turn; the output load waits for a free output
// register. No words are taken until the row's last result has been loaded.
// Synchronous active-high reset clears the sum, count, read index, sequencer and output valid.
`default_nettype none
module rootsift_row_normalizer #(
   parameter int ROW_LEN = rsn_pkg::ROW_LEN_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // input words
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] element_value
   input  wire logic        req_tlast,   // row_last
   // result words
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [15:0] root_value
   output logic             rsp_tlast    // out_last
);

   localparam int ELEM_W = rsn_pkg::ELEM_W;
   localparam int IDX_W  = $clog2(ROW_LEN);
   localparam int CNT_W  = $clog2(ROW_LEN + 1);
   localparam int SUM_W  = ELEM_W + IDX_W;   // ROW_LEN * 65535 never wraps

   rsn_pkg::state_type state_ff, state_in;

   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              ram_we, ram_re;
   logic [ELEM_W-1:0] ram_rdata;
   logic              div_start, sqrt_start;
   logic              accept, row_close, row_end, load_out;
   logic [CNT_W-1:0]  count_inc;
   logic [ELEM_W-1:0] result;

   rsn_pkg::div_status_type  div_st;
   rsn_pkg::sqrt_status_type sqrt_st;

   // Hold the row; write at the arrival index, read back in arrival order.
   rsn_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (ROW_LEN)
   ) u_store (
      .clock      (clock),
      .wr_en      (ram_we),
      .wr_addr    (count_ff[IDX_W-1:0]),
      .wr_data    (req_tdata),
      .rd_en      (ram_re),
      .rd_addr    (idx_ff),
      .rd_data_ff (ram_rdata)
   );

   // Quotient element * 2^32 / sum, one bit per cycle; sum_ff holds during emission.
   rsn_divider #(
      .SUM_W (SUM_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ram_rdata),
      .divisor  (sum_ff),
      .status   (div_st)
   );

   // Square root of the low 32 quotient bits; the top bit only marks 1.0.
   rsn_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (div_st.quotient[rsn_pkg::FRAC_SHIFT-1:0]),
      .status   (sqrt_st)
   );

   always_comb begin
      count_inc = count_ff + 1'b1;
      accept    = (state_ff == rsn_pkg::ST_LOAD) && req_tvalid;
      row_close = req_tlast || (count_inc == CNT_W'(ROW_LEN));
      row_end   = ((CNT_W'(idx_ff) + 1'b1) == count_ff);

      // zero sum gives zero; element equal to the sum saturates
      priority if (sum_ff == '0) begin
         result = '0;
      end else if (div_st.quotient[rsn_pkg::QUOT_W-1]) begin
         result = '1;
      end else begin
         result = sqrt_st.root;
      end
   end

   // Sequencer: load words, then walk the store one entry at a time.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      ram_we     = 1'b0;
      ram_re     = 1'b0;
      div_start  = 1'b0;
      sqrt_start = 1'b0;
      load_out   = 1'b0;

      unique case (state_ff)
         rsn_pkg::ST_LOAD: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ram_we = 1'b1;
               if (row_close) begin
                  state_in = rsn_pkg::ST_FETCH;
               end
            end
         end
         rsn_pkg::ST_FETCH: begin
            ram_re   = 1'b1;
            state_in = rsn_pkg::ST_START;
         end
         rsn_pkg::ST_START: begin
            div_start = 1'b1;
            state_in  = rsn_pkg::ST_DIV;
         end
         rsn_pkg::ST_DIV: begin
            if (div_st.done) begin
               sqrt_start = 1'b1;
               state_in   = rsn_pkg::ST_SQRT;
            end
         end
         rsn_pkg::ST_SQRT: begin
            if (sqrt_st.done) begin
               state_in = rsn_pkg::ST_PUT;
            end
         end
         rsn_pkg::ST_PUT: begin
            // wait for a free output register, then advance or drop back to loading
            if (!rsp_valid_ff || rsp_tready) begin
               load_out = 1'b1;
               state_in = row_end ? rsn_pkg::ST_LOAD : rsn_pkg::ST_FETCH;
            end
         end
         default: begin
            state_in = rsn_pkg::ST_LOAD;
         end
      endcase
   end

   // Running sum, count and read index.
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      if (accept) begin
         sum_in   = sum_ff + SUM_W'(req_tdata);
         count_in = count_inc;
      end
      if (load_out) begin
         if (row_end) begin
            sum_in   = '0;
            count_in = '0;
            idx_in   = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   // Output register parts the result side from the sequencer.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
         rsp_last_in  = row_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rsn_pkg::ST_LOAD;
         sum_ff       <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

[hw/rtl/rsn_checker.sv]
// Port-level checks for the RootSIFT row normalizer, bound to the top level.
`default_nettype none
module rsn_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tlast
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // closing a row with tlast stops intake
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken right after row close");

   // no intake while a row is still being emitted
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("input taken in the middle of a row's results");

   // reset empties the output register
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind rootsift_row_normalizer rsn_checker u_rsn_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
